[rtl/calendar_date_stepper_macros.svh]
// assertion macros for the calendar date stepper
// no dependencies; included by the top level only
`ifndef CALENDAR_DATE_STEPPER_MACROS_SVH
`define CALENDAR_DATE_STEPPER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, disabled in reset
`define CDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("calendar_date_stepper assertion failed");
// next-cycle implication, disabled in reset
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("calendar_date_stepper assertion failed");
`else
`define CDS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[rtl/cds_pkg.sv]
// shared types, constants and calendar functions for the date stepper
// no dependencies
package cds_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;

    localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0]  YEAR_MIN     = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_RESET   = YEAR_W'(2023);
    localparam logic [YEAR_W-1:0]  YEAR_DEFAULT = YEAR_W'(2000);
    localparam logic [MONTH_W-1:0] MONTH_FIRST  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_LAST   = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
    localparam logic [DAY_W-1:0]   DAY_LAST_DEC = DAY_W'(31);

    // y / 100 = (y * 5243) >> 19, exact for every 14-bit year
    localparam int Q_W         = 8;
    localparam int LEAP_RECIP  = 5243;
    localparam int LEAP_SHIFT  = 19;
    localparam int PROD_W      = 27;
    localparam int CENTURY     = 100;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_DIV,
        S_LD_CHK,
        S_STEP,
        S_RECALC1,
        S_RECALC2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch_in;
        logic leap_in;
        logic leap_cur;
        logic commit_load;
        logic step;
        logic set_lim;
        logic leap_upd;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic at_bound;
        logic year_wrap;
        logic out_free;
    } t_dp_status;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
            4'd2:                    len = leap ? DAY_W'(29) : DAY_W'(28);
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:      len = DAY_W'(31);
            default:                 len = '0;
        endcase
        return len;
    endfunction

endpackage

[rtl/calendar_date_stepper.sv]
// top level of the gregorian date stepper: controller plus datapath
// depends on cds_pkg, cds_ctrl, cds_dp and calendar_date_stepper_macros.svh
//
//  channel | dir | handshake              | contents
//  --------+-----+------------------------+---------------------------------------
//  s       | in  | i_s_tvalid/o_s_tready  | one command word: load date or add days
//  m       | out | o_m_tvalid/i_m_tready  | one result word per command
//
// load: latch, divide by 100, check, emit, in that order from accept to result
// add: one day per cycle through the step logic, paused at each year boundary
//      crossed for the leap flag recompute (S_RECALC1, S_RECALC2)
// synchronous active-low reset; date comes up as 1/1/2023, no result pending
// a word is accepted only while idle; a held result does not block the next
// accept, only the emit of the following result
`include "calendar_date_stepper_macros.svh"

module calendar_date_stepper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // day_in[4:0] month_in[8:5] year_in[22:9] day_count[38:23]
    input  logic        i_s_tuser,   // command
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // day_out[4:0] month_out[8:5] year_out[22:9]
    output logic [1:0]  o_m_tuser    // load_invalid[0] limit_hit[1]
);
    import cds_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    logic [DAY_W-1:0]         day_out;
    logic [MONTH_W-1:0]       month_out;
    logic [YEAR_W-1:0]        year_out;
    logic                     load_invalid;
    logic                     limit_hit;
    logic signed [COUNT_WIDTH-1:0] day_count;

    assign day_count = i_s_tdata[23 +: COUNT_WIDTH];

    // sequencing: idle, load check, stepping loop, result hand-off
    cds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_in_cmd   (i_s_tuser),
        .o_in_ready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // date registers, day step logic, leap evaluator and result register
    cds_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_day_in       (i_s_tdata[4:0]),
        .i_month_in     (i_s_tdata[8:5]),
        .i_year_in      (i_s_tdata[22:9]),
        .i_day_count    (day_count),
        .i_out_ready    (i_m_tready),
        .o_out_valid    (o_m_tvalid),
        .o_day          (day_out),
        .o_month        (month_out),
        .o_year         (year_out),
        .o_load_invalid (load_invalid),
        .o_limit_hit    (limit_hit)
    );

    // pack the result word, top bit padded with zero
    assign o_m_tdata = {1'b0, year_out, month_out, day_out};
    assign o_m_tuser = {limit_hit, load_invalid};

    // block is busy right after taking a word
    `CDS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // a rejected load always reports the default date
    `CDS_ASSERT_NOW(a_invalid_default, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0],
        (day_out == DAY_FIRST) && (month_out == MONTH_FIRST) && (year_out == YEAR_DEFAULT))

    // a limit stop leaves the date sitting on one of the two bounds
    `CDS_ASSERT_NOW(a_limit_at_bound, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1],
        ((day_out == DAY_LAST_DEC) && (month_out == MONTH_LAST) && (year_out == YEAR_MAX)) ||
        ((day_out == DAY_FIRST) && (month_out == MONTH_FIRST) && (year_out == YEAR_MIN)))

    // the two flags never come together
    `CDS_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_m_tvalid, !(o_m_tuser[0] && o_m_tuser[1]))

endmodule

[rtl/cds_leap.sv]
// two-stage leap year evaluator: registered quotient by 100, then residue check
// depends on cds_pkg
module cds_leap (
    input  logic                      i_clk,
    input  logic                      i_load,
    input  logic [cds_pkg::YEAR_W-1:0] i_year,
    output logic                      o_leap
);
    import cds_pkg::*;

    logic [YEAR_W-1:0] r_year;
    logic [Q_W-1:0]    r_q;
    logic [PROD_W-1:0] prod;
    logic [YEAR_W-1:0] rem;

    assign prod = PROD_W'(i_year) * PROD_W'(LEAP_RECIP);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_year <= i_year;
            r_q    <= prod[LEAP_SHIFT +: Q_W];
        end
    end

    // remainder by 100; divisible by 400 when also the quotient is a multiple of 4
    assign rem    = r_year - YEAR_W'(r_q * YEAR_W'(CENTURY));
    assign o_leap = ((r_year[1:0] == 2'b00) && (rem != '0)) ||
                    ((rem == '0) && (r_q[1:0] == 2'b00));

endmodule

[rtl/cds_dp.sv]
// datapath: operand latches, current date, day step logic and result register
// depends on cds_pkg and cds_leap
module cds_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cds_pkg::t_dp_cmd                    i_cmd,
    output cds_pkg::t_dp_status                 o_status,
    input  logic [cds_pkg::DAY_W-1:0]           i_day_in,
    input  logic [cds_pkg::MONTH_W-1:0]         i_month_in,
    input  logic [cds_pkg::YEAR_W-1:0]          i_year_in,
    input  logic signed [cds_pkg::COUNT_WIDTH-1:0] i_day_count,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [cds_pkg::DAY_W-1:0]           o_day,
    output logic [cds_pkg::MONTH_W-1:0]         o_month,
    output logic [cds_pkg::YEAR_W-1:0]          o_year,
    output logic                                o_load_invalid,
    output logic                                o_limit_hit
);
    import cds_pkg::*;

    logic [DAY_W-1:0]       r_day_in;
    logic [MONTH_W-1:0]     r_month_in;
    logic [YEAR_W-1:0]      r_year_in;
    logic [COUNT_WIDTH-1:0] r_count;
    logic                   r_neg;
    logic [DAY_W-1:0]       r_day,   n_day;
    logic [MONTH_W-1:0]     r_month, n_month;
    logic [YEAR_W-1:0]      r_year,  n_year;
    logic                   r_leap;
    logic                   r_inv, r_lim;
    logic                   r_o_valid;
    logic [DAY_W-1:0]       r_o_day;
    logic [MONTH_W-1:0]     r_o_month;
    logic [YEAR_W-1:0]      r_o_year;
    logic                   r_o_inv, r_o_lim;

    logic [COUNT_WIDTH-1:0] raw, mag;
    logic [DAY_W-1:0]       cur_len, prev_len, in_len;
    logic [MONTH_W-1:0]     prev_month;
    logic                   in_leap, load_ok;
    logic [YEAR_W-1:0]      leap_year;

    assign raw = COUNT_WIDTH'(i_day_count);
    assign mag = raw[COUNT_WIDTH-1] ? COUNT_WIDTH'(~raw + 1'b1) : raw;

    assign leap_year = i_cmd.leap_cur ? r_year : r_year_in;

    cds_leap u_leap (
        .i_clk  (i_clk),
        .i_load (i_cmd.leap_in | i_cmd.leap_cur),
        .i_year (leap_year),
        .o_leap (in_leap)
    );

    assign in_len  = month_len(r_month_in, in_leap);
    assign load_ok = (r_year_in >= YEAR_MIN) && (r_year_in <= YEAR_MAX) &&
                     (r_month_in >= MONTH_FIRST) && (r_month_in <= MONTH_LAST) &&
                     (r_day_in >= DAY_FIRST) && (r_day_in <= in_len);

    assign cur_len    = month_len(r_month, r_leap);
    assign prev_month = r_month - 1'b1;
    assign prev_len   = month_len(prev_month, r_leap);

    // one day forward or backward
    always_comb begin
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        if (!r_neg) begin
            if (r_day >= cur_len) begin
                n_day = DAY_FIRST;
                if (r_month >= MONTH_LAST) begin
                    n_month = MONTH_FIRST;
                    n_year  = r_year + 1'b1;
                end else begin
                    n_month = r_month + 1'b1;
                end
            end else begin
                n_day = r_day + 1'b1;
            end
        end else begin
            if (r_day > DAY_FIRST) begin
                n_day = r_day - 1'b1;
            end else if (r_month <= MONTH_FIRST) begin
                n_month = MONTH_LAST;
                n_year  = r_year - 1'b1;
                n_day   = DAY_LAST_DEC;
            end else begin
                n_month = prev_month;
                n_day   = prev_len;
            end
        end
    end

    assign o_status.cnt_zero  = (r_count == '0);
    assign o_status.at_bound  = r_neg ?
        ((r_year <= YEAR_MIN) && (r_month == MONTH_FIRST) && (r_day <= DAY_FIRST)) :
        ((r_year >= YEAR_MAX) && (r_month == MONTH_LAST) && (r_day >= DAY_LAST_DEC));
    assign o_status.year_wrap = r_neg ?
        ((r_day <= DAY_FIRST) && (r_month <= MONTH_FIRST)) :
        ((r_day >= cur_len) && (r_month >= MONTH_LAST));
    assign o_status.out_free  = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_day_in   <= i_day_in;
            r_month_in <= i_month_in;
            r_year_in  <= i_year_in;
            r_neg      <= raw[COUNT_WIDTH-1];
            r_count    <= mag;
        end else if (i_cmd.step) begin
            r_count    <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day   <= DAY_FIRST;
            r_month <= MONTH_FIRST;
            r_year  <= YEAR_RESET;
            r_leap  <= 1'b0;
            r_inv   <= 1'b0;
            r_lim   <= 1'b0;
        end else begin
            if (i_cmd.latch_in) begin
                r_inv <= 1'b0;
                r_lim <= 1'b0;
            end
            if (i_cmd.commit_load) begin
                if (load_ok) begin
                    r_day   <= r_day_in;
                    r_month <= r_month_in;
                    r_year  <= r_year_in;
                    r_leap  <= in_leap;
                end else begin
                    r_day   <= DAY_FIRST;
                    r_month <= MONTH_FIRST;
                    r_year  <= YEAR_DEFAULT;
                    r_leap  <= 1'b1;
                    r_inv   <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
            end
            if (i_cmd.set_lim) begin
                r_lim <= 1'b1;
            end
            if (i_cmd.leap_upd) begin
                r_leap <= in_leap;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_day   <= r_day;
            r_o_month <= r_month;
            r_o_year  <= r_year;
            r_o_inv   <= r_inv;
            r_o_lim   <= r_lim;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_day          = r_o_day;
    assign o_month        = r_o_month;
    assign o_year         = r_o_year;
    assign o_load_invalid = r_o_inv;
    assign o_limit_hit    = r_o_lim;

endmodule

[rtl/cds_ctrl.sv]
// controller state machine: sequences load checks, day steps and leap updates
// depends on cds_pkg
module cds_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_cmd,
    output logic                o_in_ready,
    input  cds_pkg::t_dp_status i_status,
    output cds_pkg::t_dp_cmd    o_cmd
);
    import cds_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_cmd == CMD_LOAD) ? S_LD_DIV : S_STEP;
                end
            end
            S_LD_DIV:  n_state = S_LD_CHK;
            S_LD_CHK:  n_state = S_DONE;
            S_STEP: begin
                if (i_status.cnt_zero || i_status.at_bound) begin
                    n_state = S_DONE;
                end else if (i_status.year_wrap) begin
                    n_state = S_RECALC1;
                end
            end
            S_RECALC1: n_state = S_RECALC2;
            S_RECALC2: n_state = S_STEP;
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready        = (r_state == S_IDLE);
        o_cmd             = '0;
        o_cmd.latch_in    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.leap_in     = (r_state == S_LD_DIV);
        o_cmd.commit_load = (r_state == S_LD_CHK);
        o_cmd.step        = (r_state == S_STEP) && !i_status.cnt_zero && !i_status.at_bound;
        o_cmd.set_lim     = (r_state == S_STEP) && !i_status.cnt_zero && i_status.at_bound;
        o_cmd.leap_cur    = (r_state == S_RECALC1);
        o_cmd.leap_upd    = (r_state == S_RECALC2);
        o_cmd.emit        = (r_state == S_DONE) && i_status.out_free;
    end

endmodule

[tb/calendar_date_stepper_check.sv]
`timescale 1ns / 100ps
// scoreboard for the date stepper: watches the command and result words,
// predicts each result from its own copy of the date and compares field by field
// depends on cds_pkg for field widths, date bounds and command codes

module calendar_date_stepper_check (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // day_in[4:0] month_in[8:5] year_in[22:9] day_count[38:23]
    input  logic        i_s_tuser,   // command
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // day_out[4:0] month_out[8:5] year_out[22:9]
    input  logic [1:0]  i_m_tuser,   // load_invalid[0] limit_hit[1]
    output int          o_fail_count,
    output int          o_pending
);
    import cds_pkg::*;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               invalid;
        logic               limit;
    } t_date_word;

    // predicted calendar state
    logic [DAY_W-1:0]   cur_day   = DAY_FIRST;
    logic [MONTH_W-1:0] cur_month = MONTH_FIRST;
    logic [YEAR_W-1:0]  cur_year  = YEAR_RESET;

    t_date_word dates_due[$];
    int         mismatches = 0;
    int         pending_n  = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;

    function automatic logic [DAY_W-1:0] days_in(logic [MONTH_W-1:0] m,
                                                 logic [YEAR_W-1:0] y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:               return 0;
        endcase
    endfunction

    function automatic bit day_forward();
        if (cur_year >= YEAR_MAX && cur_month == MONTH_LAST && cur_day >= DAY_LAST_DEC)
            return 1'b0;
        if (cur_day >= days_in(cur_month, cur_year)) begin
            cur_day = DAY_FIRST;
            if (cur_month >= MONTH_LAST) begin
                cur_month = MONTH_FIRST;
                cur_year  = cur_year + 1'b1;
            end else begin
                cur_month = cur_month + 1'b1;
            end
        end else begin
            cur_day = cur_day + 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic bit day_backward();
        if (cur_year <= YEAR_MIN && cur_month == MONTH_FIRST && cur_day <= DAY_FIRST)
            return 1'b0;
        if (cur_day > DAY_FIRST) begin
            cur_day = cur_day - 1'b1;
        end else begin
            if (cur_month <= MONTH_FIRST) begin
                cur_month = MONTH_LAST;
                cur_year  = cur_year - 1'b1;
            end else begin
                cur_month = cur_month - 1'b1;
            end
            cur_day = days_in(cur_month, cur_year);
        end
        return 1'b1;
    endfunction

    function automatic t_date_word predict_date(logic cmd, logic [DAY_W-1:0] d,
                                                logic [MONTH_W-1:0] m,
                                                logic [YEAR_W-1:0] y,
                                                logic [COUNT_WIDTH-1:0] cnt);
        t_date_word res;
        int         steps;
        bit         back;
        res = '0;
        if (cmd == CMD_LOAD) begin
            if (y < YEAR_MIN || y > YEAR_MAX || m < MONTH_FIRST || m > MONTH_LAST ||
                d < DAY_FIRST || d > days_in(m, y)) begin
                cur_day     = DAY_FIRST;
                cur_month   = MONTH_FIRST;
                cur_year    = YEAR_DEFAULT;
                res.invalid = 1'b1;
            end else begin
                cur_day   = d;
                cur_month = m;
                cur_year  = y;
            end
        end else begin
            steps = $signed(cnt);
            back  = steps < 0;
            if (back)
                steps = -steps;
            // remaining steps are dropped once a bound is met
            while (steps > 0 && !res.limit) begin
                if (back ? day_backward() : day_forward())
                    steps--;
                else
                    res.limit = 1'b1;
            end
        end
        res.day   = cur_day;
        res.month = cur_month;
        res.year  = cur_year;
        return res;
    endfunction

    task automatic note_mismatch(string what, t_date_word want, t_date_word got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected %0d/%0d/%0d inv=%b lim=%b, got %0d/%0d/%0d inv=%b lim=%b",
                     $realtime, what, want.day, want.month, want.year, want.invalid,
                     want.limit, got.day, got.month, got.year, got.invalid, got.limit);
    endtask

    always @(posedge i_clk) begin : watch
        t_date_word got;
        t_date_word want;
        if (!i_rst_n) begin
            cur_day   = DAY_FIRST;
            cur_month = MONTH_FIRST;
            cur_year  = YEAR_RESET;
            dates_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.day     = i_m_tdata[4:0];
                got.month   = i_m_tdata[8:5];
                got.year    = i_m_tdata[22:9];
                got.invalid = i_m_tuser[0];
                got.limit   = i_m_tuser[1];
                if (dates_due.size() == 0) begin
                    note_mismatch("result word with no command outstanding", '0, got);
                end else begin
                    want = dates_due.pop_front();
                    if (got !== want)
                        note_mismatch("result word mismatch", want, got);
                end
            end
            if (i_s_tvalid && i_s_tready)
                dates_due.push_back(predict_date(i_s_tuser, i_s_tdata[4:0], i_s_tdata[8:5],
                                                 i_s_tdata[22:9], i_s_tdata[38:23]));
        end
        pending_n = dates_due.size();
    end

endmodule

[tb/calendar_date_stepper_tb.sv]
`timescale 1ns / 100ps
// top of the date stepper testbench: clock, reset, command stimulus and verdict
// depends on cds_pkg, calendar_date_stepper and calendar_date_stepper_check

module calendar_date_stepper_tb;
    import cds_pkg::*;

    localparam int RANDOM_WORDS = 1640;
    localparam int HOLD_EVERY   = 300;   // sender waits for all results this often

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;          // day_in[4:0] month_in[8:5] year_in[22:9] day_count[38:23]
    logic        s_tuser  = CMD_LOAD;    // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;                // day_out[4:0] month_out[8:5] year_out[22:9]
    logic [1:0]  m_tuser;                // load_invalid[0] limit_hit[1]

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int cycle_limit = 50000;             // grows with every word sent
    bit steady_run  = 1'b0;              // both sides stop idling while set

    calendar_date_stepper i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    calendar_date_stepper_check u_date_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog: the limit is raised by each word sent, for an add according to its day count
    initial begin
        while (cycle_count < cycle_limit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // result side stalls about a third of the time, never during the steady stretch
    initial begin
        forever begin
            @(negedge i_clk);
            m_tready <= steady_run || ($urandom_range(0, 99) >= 34);
        end
    end

    // month length for building valid and just-invalid dates
    function automatic int month_days(int m, int y);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            4, 6, 9, 11: return 30;
            2:           return leap ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // one command word; idles at random before it, then holds until taken
    task automatic send_word(logic cmd, logic [DAY_W-1:0] d, logic [MONTH_W-1:0] mo,
                             logic [YEAR_W-1:0] y, logic [COUNT_WIDTH-1:0] cnt);
        int mag;
        mag = $signed(cnt);
        if (mag < 0)
            mag = -mag;
        // budget for one step per day plus leap recompute at year rollover, with room for stalls
        cycle_limit += (cmd == CMD_ADD) ? 600 + 3 * mag : 600;
        @(negedge i_clk);
        while (!steady_run && $urandom_range(0, 99) < 34) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, cnt, y, mo, d};
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    // load ignores day_count, so it carries noise
    task automatic send_load(logic [DAY_W-1:0] d, logic [MONTH_W-1:0] mo,
                             logic [YEAR_W-1:0] y);
        send_word(CMD_LOAD, d, mo, y, COUNT_WIDTH'($urandom));
    endtask

    // add ignores the date fields, so they carry noise
    task automatic send_add(logic [COUNT_WIDTH-1:0] cnt);
        send_word(CMD_ADD, DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom), cnt);
    endtask

    // sender holds off until every result is back
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
    endtask

    // mostly short counts, a few long ones; lean picks the likely direction
    function automatic logic [COUNT_WIDTH-1:0] pick_count(int lean);
        int r;
        int mag;
        bit back;
        r = $urandom_range(0, 99);
        if (r < 8)
            mag = $urandom_range(0, 1);
        else if (r < 60)
            mag = $urandom_range(2, 60);
        else if (r < 88)
            mag = $urandom_range(61, 800);
        else if (r < 99)
            mag = $urandom_range(801, 2500);
        else
            mag = $urandom_range(2501, 20000);
        if (lean != 0 && $urandom_range(0, 99) < 60)
            back = lean < 0;
        else
            back = $urandom_range(0, 1);
        return back ? COUNT_WIDTH'(-mag) : COUNT_WIDTH'(mag);
    endfunction

    // valid date biased toward the year bounds, century years and month ends
    task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] mo,
                             output logic [YEAR_W-1:0] y);
        int r;
        int yy;
        int mm;
        int len;
        r = $urandom_range(0, 99);
        if (r < 15)
            yy = $urandom_range(1, 4);
        else if (r < 30)
            yy = $urandom_range(9996, 9999);
        else if (r < 50)
            yy = 100 * $urandom_range(1, 99);
        else
            yy = $urandom_range(1, 9999);
        mm  = $urandom_range(1, 12);
        len = month_days(mm, yy);
        r   = $urandom_range(0, 99);
        y   = YEAR_W'(yy);
        if (r < 30) begin
            mo = MONTH_W'(mm);
            d  = DAY_W'(len);
        end else if (r < 40) begin
            // end of february, across leap and century years
            mo = 4'd2;
            d  = DAY_W'($urandom_range(28, month_days(2, yy)));
        end else begin
            mo = MONTH_W'(mm);
            d  = DAY_W'($urandom_range(1, len));
        end
    endtask

    initial begin
        logic [DAY_W-1:0]   d;
        logic [MONTH_W-1:0] mo;
        logic [YEAR_W-1:0]  y;
        int sent;
        int next_hold;
        int r;
        int lean;
        int len;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero count at the reset date
        send_add('0);
        // leap rule: divisible by 400, century, ordinary leap, ordinary year
        send_load(29, 2, 2000);
        send_load(29, 2, 1900);
        send_load(29, 2, 2024);
        send_load(29, 2, 2023);
        // out-of-range loads: day past month end, month too high,
        // all fields at their top, all at zero, year past the upper bound
        send_load(31, 4, 2010);
        send_load(15, 13, 2010);
        send_load('1, '1, '1);
        send_load('0, '0, '0);
        send_load(1, 1, 10000);
        // bounds reached at once, both directions
        send_load(31, 12, 9999);
        send_add(1);
        send_load(1, 1, 1);
        send_add('1);
        // century year is not leap going forward, 400-year is leap going back
        send_load(28, 2, 2100);
        send_add(1);
        send_load(1, 3, 2000);
        send_add('1);
        // largest counts both ways, then both cut off by a bound midway
        send_add(16'h7fff);
        send_load(31, 12, 9999);
        send_add(16'h8000);
        send_load(1, 1, 9950);
        send_add(16'h7fff);
        send_load(1, 1, 50);
        send_add(16'h8000);
        wait_drained();

        // random: mostly a valid load followed by a few adds, some noise
        // and some loads broken in one field
        sent      = 0;
        next_hold = HOLD_EVERY;
        while (sent < RANDOM_WORDS) begin
            steady_run = (sent >= 700 && sent < 950);
            if (sent >= next_hold) begin
                wait_drained();
                next_hold += HOLD_EVERY;
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                if ($urandom_range(0, 1))
                    send_add(pick_count(0));
                else
                    send_load(DAY_W'($urandom), MONTH_W'($urandom), YEAR_W'($urandom));
                sent++;
            end else begin
                pick_date(d, mo, y);
                if (r < 22) begin
                    len = month_days(mo, y);
                    case ($urandom_range(0, 3))
                        0: d = '0;
                        1: d = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
                        2: mo = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
                        default: y = $urandom_range(0, 1) ? '0 :
                                     YEAR_W'($urandom_range(10000, 16383));
                    endcase
                end
                send_load(d, mo, y);
                sent++;
                // near a year bound, lean toward it so the limit gets reached
                lean = (y >= 9900 && y <= 9999) ? 1 : (y >= 1 && y <= 100) ? -1 : 0;
                repeat ($urandom_range(1, 5)) begin
                    send_add(pick_count(lean));
                    sent++;
                end
            end
        end
        steady_run = 1'b0;

        wait_drained();
        // room for a stray extra result to show up
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
